// ===== rtl/lpd_pkg.sv =====
// Shared types and constants of the length-prefixed deframer.
package lpd_pkg;

	localparam int unsigned HEADER_BYTES = 12;
	localparam int unsigned HDR_CNT_W = 4;
	localparam int unsigned PADDR_W = 4;
	localparam int unsigned PDATA_W = 32;

	localparam logic [HDR_CNT_W-1:0] HDR_TYPE_IDX = 4'd4;
	localparam logic [HDR_CNT_W-1:0] HDR_LAST_IDX = HDR_CNT_W'(HEADER_BYTES - 1);

	localparam logic [7:0] MAGIC [4] = '{8'h46, 8'h44, 8'h52, 8'h31};

	typedef enum logic [1:0] {
		REG_MAX_LEN  = 2'd0,
		REG_TEXT_TYP = 2'd1,
		REG_BIN_TYP  = 2'd2,
		REG_NONE     = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		KIND_BYTE  = 3'd0,
		KIND_EMPTY = 3'd1,
		KIND_BAD   = 3'd2,
		KIND_TRUNC = 3'd3,
		KIND_END   = 3'd4
	} kind_t;

	localparam logic [31:0] MAX_LEN_RST = 32'h0100_0000;
	localparam logic [7:0] TEXT_TYP_RST = 8'd1;
	localparam logic [7:0] BIN_TYP_RST = 8'd2;

endpackage

// ===== rtl/length_prefixed_deframer_top.sv =====
// Top level of the length-prefixed deframer: header check, payload pass-through, APB registers.
//
//  channel   handshake                  payload
//  item      item_valid / item_ready    stream_byte, stream_closed
//  result    result_valid / result_ready result_kind, payload_byte, frame_kind, last_of_frame
//  config    APB psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// One word per clock while item_ready is high: the accepting edge updates the parse state
// and loads the result register together, so a result is offered in the cycle right after
// its word is taken. item_ready is high whenever the result register is empty or being taken.
// Reset returns to header phase with the register reset values.
// After a bad header, truncation or end of stream no further results are produced until reset.
module length_prefixed_deframer_top
	import lpd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  logic [7:0]          stream_byte,
	input  logic                stream_closed,
	output logic                result_valid,
	input  logic                result_ready,
	output logic [2:0]          result_kind,
	output logic [7:0]          payload_byte,
	output logic [7:0]          frame_kind,
	output logic                last_of_frame,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready
);

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_HALTED  = 2'd2
	} phase_t;

	// configuration registers
	logic [31:0] max_len_q;
	logic [7:0]  text_typ_q;
	logic [7:0]  bin_typ_q;
	reg_idx_t    reg_idx;
	logic        cfg_wr;

	// parse state
	phase_t                phase_q, phase_n;
	logic [HDR_CNT_W-1:0]  hdr_cnt_q, hdr_cnt_n;
	logic                  hdr_good_q, hdr_good_n;
	logic [7:0]            cur_type_q, cur_type_n;
	logic [23:0]           len_gather_q, len_gather_n;
	logic [31:0]           bytes_left_q, bytes_left_n;

	// result register
	logic        res_valid_q;
	kind_t       res_kind_q;
	logic [7:0]  res_byte_q;
	logic [7:0]  res_type_q;
	logic        res_last_q;

	logic        emit;
	kind_t       kind_n;
	logic [7:0]  byte_n;
	logic [7:0]  type_n;
	logic        last_n;
	logic        accept;
	logic [31:0] hdr_len;
	logic        hdr_ok;

	assign pready = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_MAX_LEN:  prdata = max_len_q;
			REG_TEXT_TYP: prdata = {24'd0, text_typ_q};
			REG_BIN_TYP:  prdata = {24'd0, bin_typ_q};
			REG_NONE:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RST;
			text_typ_q <= TEXT_TYP_RST;
			bin_typ_q <= BIN_TYP_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_MAX_LEN:  max_len_q <= pwdata;
				REG_TEXT_TYP: text_typ_q <= pwdata[7:0];
				REG_BIN_TYP:  bin_typ_q <= pwdata[7:0];
				REG_NONE:     ;
			endcase
		end
	end

	assign item_ready = !res_valid_q || result_ready;
	assign accept = item_valid && item_ready;

	// the twelfth word carries the top length byte, so the judged length includes it directly
	assign hdr_len = {stream_byte, len_gather_q};
	assign hdr_ok = hdr_good_q && (hdr_len <= max_len_q)
		&& ((cur_type_q == text_typ_q) || (cur_type_q == bin_typ_q));

	always_comb begin
		phase_n = phase_q;
		hdr_cnt_n = hdr_cnt_q;
		hdr_good_n = hdr_good_q;
		cur_type_n = cur_type_q;
		len_gather_n = len_gather_q;
		bytes_left_n = bytes_left_q;
		emit = 1'b0;
		kind_n = KIND_END;
		byte_n = '0;
		type_n = '0;
		last_n = 1'b0;
		unique case (phase_q)
			PH_HEADER: begin
				if (stream_closed) begin
					phase_n = PH_HALTED;
					emit = 1'b1;
					kind_n = KIND_END;
				end else begin
					unique case (hdr_cnt_q)
						4'd0, 4'd1, 4'd2, 4'd3: begin
							if (stream_byte != MAGIC[hdr_cnt_q[1:0]])
								hdr_good_n = 1'b0;
						end
						HDR_TYPE_IDX: cur_type_n = stream_byte;
						4'd5, 4'd6, 4'd7: begin
							if (stream_byte != 8'd0)
								hdr_good_n = 1'b0;
						end
						4'd8:  len_gather_n[7:0] = stream_byte;
						4'd9:  len_gather_n[15:8] = stream_byte;
						4'd10: len_gather_n[23:16] = stream_byte;
						default: ;
					endcase
					if (hdr_cnt_q != HDR_LAST_IDX) begin
						hdr_cnt_n = hdr_cnt_q + 1'b1;
					end else if (!hdr_ok) begin
						phase_n = PH_HALTED;
						emit = 1'b1;
						kind_n = KIND_BAD;
					end else begin
						hdr_cnt_n = '0;
						hdr_good_n = 1'b1;
						len_gather_n = '0;
						if (hdr_len == 32'd0) begin
							emit = 1'b1;
							kind_n = KIND_EMPTY;
							type_n = cur_type_q;
							last_n = 1'b1;
							cur_type_n = '0;
						end else begin
							bytes_left_n = hdr_len;
							phase_n = PH_PAYLOAD;
						end
					end
				end
			end
			PH_PAYLOAD: begin
				emit = 1'b1;
				if (stream_closed) begin
					phase_n = PH_HALTED;
					kind_n = KIND_TRUNC;
				end else begin
					bytes_left_n = bytes_left_q - 32'd1;
					kind_n = KIND_BYTE;
					byte_n = stream_byte;
					type_n = cur_type_q;
					last_n = (bytes_left_q == 32'd1);
					if (last_n) begin
						phase_n = PH_HEADER;
						hdr_cnt_n = '0;
						hdr_good_n = 1'b1;
						cur_type_n = '0;
						len_gather_n = '0;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hdr_cnt_q <= '0;
			hdr_good_q <= 1'b1;
			cur_type_q <= '0;
			len_gather_q <= '0;
			bytes_left_q <= '0;
			res_valid_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_n;
			hdr_cnt_q <= hdr_cnt_n;
			hdr_good_q <= hdr_good_n;
			cur_type_q <= cur_type_n;
			len_gather_q <= len_gather_n;
			bytes_left_q <= bytes_left_n;
			res_valid_q <= emit;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			res_kind_q <= kind_n;
			res_byte_q <= byte_n;
			res_type_q <= type_n;
			res_last_q <= last_n;
		end
	end

	assign result_valid = res_valid_q;
	assign result_kind = res_kind_q;
	assign payload_byte = res_byte_q;
	assign frame_kind = res_type_q;
	assign last_of_frame = res_last_q;

endmodule

// ===== rtl/lpd_checker.sv =====
// Port-level checks of the length-prefixed deframer, bound to the top level.
module lpd_checker
	import lpd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       result_valid,
	input  logic       result_ready,
	input  logic [2:0] result_kind,
	input  logic [7:0] payload_byte,
	input  logic [7:0] frame_kind,
	input  logic       last_of_frame
);

	// errors and end of stream are terminal: nothing follows once taken
	a_halt_after_terminal: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && (result_kind == KIND_BAD
			|| result_kind == KIND_TRUNC || result_kind == KIND_END)
		|=> !result_valid)
		else $error("result after terminal word");

	a_byte_only_for_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_kind != KIND_BYTE) |-> (payload_byte == 8'd0))
		else $error("payload byte set on non-data result");

	a_last_only_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_of_frame |-> (result_kind == KIND_BYTE || result_kind == KIND_EMPTY))
		else $error("last marker on non-frame result");

	a_type_only_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !(result_kind == KIND_BYTE || result_kind == KIND_EMPTY)
		|-> (frame_kind == 8'd0 && !last_of_frame))
		else $error("frame type on non-frame result");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_kind)
			&& $stable(payload_byte) && $stable(frame_kind) && $stable(last_of_frame))
		else $error("result changed while stalled");

endmodule

bind length_prefixed_deframer_top lpd_checker u_lpd_checker (.*);
